// ----- rtl/core/slcrd_pkg.sv -----
package slcrd_pkg;

  localparam int unsigned ClassW  = 4;
  localparam int unsigned ColW    = 8;
  localparam int unsigned LineW   = 8;
  localparam int unsigned GapW    = 4;
  localparam int unsigned WidthW  = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [CfgIdxW-1:0] CfgTargetClass = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRunGap      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinWidth    = 2'd2;

  localparam logic [ClassW-1:0] TargetClassRst = 4'd0;
  localparam logic [GapW-1:0]   RunGapRst      = 4'd4;
  localparam logic [WidthW-1:0] MinWidthRst    = 9'd15;

  typedef struct packed {
    logic             is_target;
    logic [ColW-1:0]  column;
    logic [LineW-1:0] line_index;
    logic             line_end;
    logic             frame_end;
  } pix_t;

  typedef struct packed {
    logic [GapW-1:0]   run_gap;
    logic [WidthW-1:0] min_width;
  } cfg_t;

  typedef struct packed {
    logic full;
  } fifo_stat_t;

endpackage

// ----- rtl/core/scan_line_color_run_detector_unit.sv -----
// Throughput: one pixel per cycle, sustained while the result side keeps up.
// A frame_end pixel's result passes through the pixel queue and then the result
//   register before it shows on m_axis; pixels queued ahead of it go first.
// The queue (FIFO_DEPTH entries) absorbs result-side stalls.
// Reset (rst_ni, async, active low) clears the queue, line and frame state
//   and loads the default register values; no clearing pass is needed.
module scan_line_color_run_detector_unit #(
  parameter int unsigned FIFO_DEPTH = slcrd_pkg::FifoDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [slcrd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [slcrd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] pixel_class, [11:4] column, [19:12] line_index, [23:20] zero
  input  logic [slcrd_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                               s_axis_tlast,  // line_end
  input  logic                               s_axis_tuser,  // frame_end
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] best_left, [15:8] best_right, [24:16] best_width,
  // [32:25] best_center, [40:33] best_line, [47:41] zero
  output logic [slcrd_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                               m_axis_tuser   // found
);

  slcrd_pkg::fifo_stat_t          fifo_stat;
  slcrd_pkg::pix_t                push_item, head;
  slcrd_pkg::cfg_t                cfg;
  logic                           push, pop, head_valid;
  logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count;

  slcrd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .s_axis_tuser,
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .item_o      (push_item),
    .cfg_o       (cfg)
  );

  slcrd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .item_i       (push_item),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .stat_o       (fifo_stat),
    .count_o      (fifo_count)
  );

  slcrd_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

`ifndef SYNTHESIS
  a_result_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop && head.frame_end))
    else $error("result raised without a frame_end pixel leaving the queue");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.frame_end) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_queue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (fifo_count == $past(fifo_count) + 1'b1))
    else $error("queue count lost a transfer");
`endif

endmodule

// ----- rtl/core/slcrd_front.sv -----
module slcrd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [slcrd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [slcrd_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [slcrd_pkg::InDataW-1:0]       s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tuser,
  input  slcrd_pkg::fifo_stat_t               fifo_stat_i,
  output logic                                push_o,
  output slcrd_pkg::pix_t                     item_o,
  output slcrd_pkg::cfg_t                     cfg_o
);

  logic [slcrd_pkg::ClassW-1:0] target_class_q;
  logic [slcrd_pkg::GapW-1:0]   run_gap_q;
  logic [slcrd_pkg::WidthW-1:0] min_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_class_q <= slcrd_pkg::TargetClassRst;
      run_gap_q      <= slcrd_pkg::RunGapRst;
      min_width_q    <= slcrd_pkg::MinWidthRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        slcrd_pkg::CfgTargetClass: target_class_q <= cfg_data_i[slcrd_pkg::ClassW-1:0];
        slcrd_pkg::CfgRunGap:      run_gap_q      <= cfg_data_i[slcrd_pkg::GapW-1:0];
        slcrd_pkg::CfgMinWidth:    min_width_q    <= cfg_data_i[slcrd_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !fifo_stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  assign item_o.is_target  = (s_axis_tdata[3:0] == target_class_q);
  assign item_o.column     = s_axis_tdata[11:4];
  assign item_o.line_index = s_axis_tdata[19:12];
  assign item_o.line_end   = s_axis_tlast;
  assign item_o.frame_end  = s_axis_tuser;

  assign cfg_o.run_gap   = run_gap_q;
  assign cfg_o.min_width = min_width_q;

endmodule

// ----- rtl/core/slcrd_fifo.sv -----
module slcrd_fifo #(
  parameter int unsigned DEPTH = slcrd_pkg::FifoDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  slcrd_pkg::pix_t       item_i,
  input  logic                  pop_i,
  output slcrd_pkg::pix_t       head_o,
  output logic                  head_valid_o,
  output slcrd_pkg::fifo_stat_t stat_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH+1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH-1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  slcrd_pkg::pix_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign stat_o.full  = (count_q == FullCnt);
  assign count_o      = count_q;

endmodule

// ----- rtl/core/slcrd_back.sv -----
module slcrd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  slcrd_pkg::cfg_t                 cfg_i,
  input  slcrd_pkg::pix_t                 head_i,
  input  logic                            head_valid_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [slcrd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser
);

  localparam logic [1:0] MODE_SEEK = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  localparam int unsigned ColW = slcrd_pkg::ColW;
  localparam int unsigned WW   = slcrd_pkg::WidthW;
  localparam int unsigned GW   = slcrd_pkg::GapW;

  logic [1:0]           mode_q, mode_d;
  logic [GW-1:0]        gap_q, gap_d;
  logic [ColW-1:0]      left_q, left_d, right_q, right_d;
  logic [WW-1:0]        max_width_q, max_width_d;
  logic [ColW-1:0]      max_left_q, max_left_d, max_right_q, max_right_d;
  logic [ColW-1:0]      max_line_q, max_line_d;

  logic                 out_valid_q;
  logic [WW-1:0]        out_width_q;
  logic [ColW-1:0]      out_left_q, out_right_q, out_line_q;

  logic [GW:0]          gap_next;
  logic                 gap_over;
  logic [1:0]           mode_s;
  logic [GW-1:0]        gap_s;
  logic [ColW-1:0]      left_s, right_s;
  logic [WW-1:0]        line_width;
  logic                 wider;
  logic                 close;
  logic [ColW:0]        center_sum;

  assign pop_o = head_valid_i &&
                 (!head_i.frame_end || !out_valid_q || m_axis_tready);

  assign gap_next = {1'b0, gap_q} + 1'b1;
  assign gap_over = (gap_next > {1'b0, cfg_i.run_gap});

  always_comb begin
    mode_s  = mode_q;
    gap_s   = gap_q;
    left_s  = left_q;
    right_s = right_q;
    if (head_i.is_target) begin
      if (mode_q == MODE_SEEK) begin
        if (gap_over) begin
          left_s  = (head_i.column >= {{(ColW-GW){1'b0}}, cfg_i.run_gap}) ?
                    head_i.column - {{(ColW-GW){1'b0}}, cfg_i.run_gap} : '0;
          right_s = head_i.column;
          gap_s   = '0;
          mode_s  = MODE_RUN;
        end else begin
          gap_s = gap_next[GW-1:0];
        end
      end else if (mode_q == MODE_RUN) begin
        right_s = head_i.column;
        gap_s   = '0;
      end
    end else begin
      if (mode_q == MODE_SEEK) begin
        gap_s = '0;
      end else if (mode_q == MODE_RUN) begin
        if (gap_over) begin
          mode_s = MODE_DONE;
          gap_s  = '0;
        end else begin
          gap_s = gap_next[GW-1:0];
        end
      end
    end
  end

  always_comb begin
    line_width = '0;
    if (mode_s != MODE_SEEK && right_s >= left_s) begin
      line_width = {1'b0, right_s} - {1'b0, left_s} + 1'b1;
    end
  end

  assign close = head_i.line_end || head_i.frame_end;
  assign wider = close && (line_width > max_width_q);

  always_comb begin
    mode_d      = mode_s;
    gap_d       = gap_s;
    left_d      = left_s;
    right_d     = right_s;
    max_width_d = max_width_q;
    max_left_d  = max_left_q;
    max_right_d = max_right_q;
    max_line_d  = max_line_q;
    if (wider) begin
      max_width_d = line_width;
      max_left_d  = left_s;
      max_right_d = right_s;
      max_line_d  = head_i.line_index;
    end
    if (close) begin
      mode_d  = MODE_SEEK;
      gap_d   = '0;
      left_d  = '0;
      right_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SEEK;
      gap_q       <= '0;
      left_q      <= '0;
      right_q     <= '0;
      max_width_q <= '0;
      max_left_q  <= '0;
      max_right_q <= '0;
      max_line_q  <= '0;
    end else if (pop_o) begin
      mode_q  <= mode_d;
      gap_q   <= gap_d;
      left_q  <= left_d;
      right_q <= right_d;
      if (head_i.frame_end) begin
        max_width_q <= '0;
        max_left_q  <= '0;
        max_right_q <= '0;
        max_line_q  <= '0;
      end else begin
        max_width_q <= max_width_d;
        max_left_q  <= max_left_d;
        max_right_q <= max_right_d;
        max_line_q  <= max_line_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && head_i.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.frame_end) begin
      out_width_q <= max_width_d;
      out_left_q  <= max_left_d;
      out_right_q <= max_right_d;
      out_line_q  <= max_line_d;
    end
  end

  assign center_sum = {1'b0, out_left_q} + {1'b0, out_right_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = (out_width_q > cfg_i.min_width);
  assign m_axis_tdata  = {7'd0, out_line_q, center_sum[ColW:1], out_width_q,
                          out_right_q, out_left_q};

endmodule

// ----- tb/scan_line_color_run_detector_unit_test.sv -----
`timescale 1ns / 1ps

module scan_line_color_run_detector_unit_test;

  localparam int unsigned ClassW   = slcrd_pkg::ClassW;
  localparam int unsigned ColW     = slcrd_pkg::ColW;
  localparam int unsigned LineW    = slcrd_pkg::LineW;
  localparam int unsigned GapW     = slcrd_pkg::GapW;
  localparam int unsigned WidthW   = slcrd_pkg::WidthW;
  localparam int unsigned CfgIdxW  = slcrd_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = slcrd_pkg::CfgDataW;
  localparam int unsigned InDataW  = slcrd_pkg::InDataW;
  localparam int unsigned OutDataW = slcrd_pkg::OutDataW;

  localparam int unsigned FIFO_DEPTH     = slcrd_pkg::FifoDepthDefault;
  localparam int unsigned DRAIN_CYCLES   = FIFO_DEPTH + 6;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS   = 700;
  localparam int unsigned MIN_REPORTS    = 40;
  localparam int unsigned MAX_PRINTS     = 50;

  typedef enum logic [1:0] {
    SEEKING    = 2'd0,
    IN_RUN     = 2'd1,
    RUN_CLOSED = 2'd2
  } run_state_e;

  typedef struct packed {
    logic              found;
    logic [ColW-1:0]   left_col;
    logic [ColW-1:0]   right_col;
    logic [WidthW-1:0] width;
    logic [ColW-1:0]   center_col;
    logic [LineW-1:0]  line_idx;
  } run_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  scan_line_color_run_detector_unit #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // predictor: register copies, line state, frame record
  logic [ClassW-1:0] target_cls = slcrd_pkg::TargetClassRst;
  logic [GapW-1:0]   run_gap_len = slcrd_pkg::RunGapRst;
  logic [WidthW-1:0] min_run_width = slcrd_pkg::MinWidthRst;
  run_state_e        run_state = SEEKING;
  logic [GapW-1:0]   gap_run = '0;
  logic [ColW-1:0]   line_left = '0;
  logic [ColW-1:0]   line_right = '0;
  logic [WidthW-1:0] best_width = '0;
  logic [ColW-1:0]   best_left = '0;
  logic [ColW-1:0]   best_right = '0;
  logic [LineW-1:0]  best_line = '0;

  run_report_t expected_reports[$];
  run_report_t want_rep;
  run_report_t got_rep;

  int unsigned mismatches = 0;
  int unsigned reports_checked = 0;
  int unsigned reports_predicted = 0;
  int unsigned pixels_sent = 0;
  int unsigned stall_cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_off_req = 1'b0;

  function automatic bit predict_pixel(input logic [ClassW-1:0] cls,
                                       input logic [ColW-1:0] col,
                                       input logic [LineW-1:0] ln,
                                       input bit lend, input bit fend,
                                       output run_report_t rep);
    int unsigned cnt;
    int unsigned w;
    cnt = gap_run + 1;
    w = 0;
    rep = '0;
    if (cls == target_cls) begin
      if (run_state == SEEKING) begin
        if (cnt > run_gap_len) begin
          line_left = (col >= run_gap_len) ? col - run_gap_len : '0;
          line_right = col;
          gap_run = '0;
          run_state = IN_RUN;
        end else begin
          gap_run = cnt[GapW-1:0];
        end
      end else if (run_state == IN_RUN) begin
        line_right = col;
        gap_run = '0;
      end
    end else if (run_state == SEEKING) begin
      gap_run = '0;
    end else if (run_state == IN_RUN) begin
      if (cnt > run_gap_len) begin
        run_state = RUN_CLOSED;
        gap_run = '0;
      end else begin
        gap_run = cnt[GapW-1:0];
      end
    end
    if (lend || fend) begin
      if (run_state != SEEKING && line_right >= line_left)
        w = int'(line_right) - int'(line_left) + 1;
      if (w > best_width) begin
        best_width = w[WidthW-1:0];
        best_left = line_left;
        best_right = line_right;
        best_line = ln;
      end
      run_state = SEEKING;
      gap_run = '0;
      line_left = '0;
      line_right = '0;
    end
    if (!fend) return 1'b0;
    rep.found = best_width > min_run_width;
    rep.left_col = best_left;
    rep.right_col = best_right;
    rep.width = best_width;
    rep.center_col = ColW'((int'(best_left) + int'(best_right)) >> 1);
    rep.line_idx = best_line;
    best_width = '0;
    best_left = '0;
    best_right = '0;
    best_line = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] result %0d mismatch: %s", $realtime, reports_checked, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rep.found = m_axis_tuser;
      got_rep.left_col = m_axis_tdata[7:0];
      got_rep.right_col = m_axis_tdata[15:8];
      got_rep.width = m_axis_tdata[24:16];
      got_rep.center_col = m_axis_tdata[32:25];
      got_rep.line_idx = m_axis_tdata[40:33];
      if (expected_reports.size() == 0) begin
        report_mismatch("result transfer with no prediction pending");
      end else begin
        want_rep = expected_reports.pop_front();
        check_field("found", got_rep.found, want_rep.found);
        check_field("best_left", got_rep.left_col, want_rep.left_col);
        check_field("best_right", got_rep.right_col, want_rep.right_col);
        check_field("best_width", got_rep.width, want_rep.width);
        check_field("best_center", got_rep.center_col, want_rep.center_col);
        check_field("best_line", got_rep.line_idx, want_rep.line_idx);
      end
      reports_checked++;
    end
  end

  initial begin : result_sink
    int unsigned pause;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        pause = rx_idle_en ? $urandom_range(0, 3) : 0;
        if (pause != 0) begin
          m_axis_tready <= 1'b0;
          repeat (pause) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_pixel(input logic [ClassW-1:0] cls, input logic [ColW-1:0] col,
                            input logic [LineW-1:0] ln, input bit lend, input bit fend);
    int unsigned pause;
    run_report_t rep;
    pause = tx_idle_en ? $urandom_range(0, 3) : 0;
    if (pause != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, ln, col, cls};
    s_axis_tlast <= lend;
    s_axis_tuser <= fend;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    if (predict_pixel(cls, col, ln, lend, fend, rep)) begin
      expected_reports.push_back(rep);
      reports_predicted++;
    end
  endtask

  // all three registers back to back, valid held high across transfers
  task automatic program_regs(input logic [ClassW-1:0] cls, input logic [GapW-1:0] gap,
                              input logic [WidthW-1:0] minw);
    logic [CfgIdxW-1:0] idx[3];
    logic [CfgDataW-1:0] val[3];
    idx[0] = slcrd_pkg::CfgTargetClass;
    idx[1] = slcrd_pkg::CfgRunGap;
    idx[2] = slcrd_pkg::CfgMinWidth;
    val[0] = CfgDataW'(cls);
    val[1] = CfgDataW'(gap);
    val[2] = CfgDataW'(minw);
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        slcrd_pkg::CfgTargetClass: target_cls = val[i][ClassW-1:0];
        slcrd_pkg::CfgRunGap:      run_gap_len = val[i][GapW-1:0];
        slcrd_pkg::CfgMinWidth:    min_run_width = val[i][WidthW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_frame();
    int unsigned n_lines;
    int unsigned len;
    int unsigned start;
    int unsigned seg_left;
    bit on_target;
    bit lend;
    bit fend;
    logic [ClassW-1:0] cls;
    logic [ColW-1:0] col;
    logic [LineW-1:0] ln;
    n_lines = $urandom_range(1, 3);
    for (int l = 0; l < n_lines; l++) begin
      len = ($urandom_range(0, 31) == 0) ? 256 : $urandom_range(1, 24);
      start = $urandom_range(0, 256 - len);
      ln = LineW'($urandom_range(0, 255));
      on_target = ($urandom_range(0, 1) != 0);
      seg_left = 0;
      for (int p = 0; p < len; p++) begin
        if (seg_left == 0) begin
          on_target = !on_target;
          seg_left = on_target ? $urandom_range(1, 2 * run_gap_len + 3)
                               : $urandom_range(1, run_gap_len + 2);
        end
        seg_left--;
        cls = on_target ? target_cls : target_cls + ClassW'($urandom_range(1, 15));
        if ($urandom_range(0, 31) == 0) cls = ClassW'($urandom_range(0, 15));
        col = ColW'(start + p);
        if ($urandom_range(0, 63) == 0) col = ColW'($urandom_range(0, 255));
        lend = (p == len - 1);
        fend = lend && (l == n_lines - 1);
        if (lend && $urandom_range(0, 7) == 0) lend = 1'b0;
        if (!fend && $urandom_range(0, 127) == 0) fend = 1'b1;
        send_pixel(cls, col, ln, lend, fend);
      end
    end
  endtask

  task automatic test_no_run_frame();
    send_pixel(4'd15, 8'd0, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic test_default_registers();
    for (int c = 251; c <= 255; c++)
      send_pixel(4'd0, c[7:0], 8'd255, c == 255, c == 255);
  endtask

  task automatic test_run_edges();
    drain_results();
    program_regs(4'd15, 4'd1, 9'd0);
    // start at column 0 with saturated left, gap inside run, end, ignored tail
    send_pixel(4'd15, 8'd0, 8'd7, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd0, 8'd7, 1'b0, 1'b0);
    send_pixel(4'd3, 8'd1, 8'd7, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd2, 8'd7, 1'b0, 1'b0);
    send_pixel(4'd3, 8'd3, 8'd7, 1'b0, 1'b0);
    send_pixel(4'd3, 8'd4, 8'd7, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd5, 8'd7, 1'b1, 1'b0);
    // equal width on a later line keeps the record
    send_pixel(4'd15, 8'd10, 8'd8, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd11, 8'd8, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd12, 8'd8, 1'b1, 1'b0);
    send_pixel(4'd0, 8'd20, 8'd9, 1'b1, 1'b0);
    // right edge falls left of left edge
    send_pixel(4'd15, 8'd50, 8'd10, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd40, 8'd10, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd5, 8'd10, 1'b1, 1'b1);
  endtask

  task automatic test_zero_gap();
    drain_results();
    program_regs(4'd15, 4'd0, 9'd256);
    send_pixel(4'd15, 8'd100, 8'd1, 1'b0, 1'b0);
    send_pixel(4'd1, 8'd101, 8'd1, 1'b0, 1'b0);
    send_pixel(4'd15, 8'd102, 8'd1, 1'b0, 1'b1);
  endtask

  task automatic test_back_pressure();
    drain_results();
    program_regs(4'd2, 4'd1, 9'd0);
    tx_idle_en = 1'b0;
    hold_off_req = 1'b1;
    for (int f = 0; f < 40; f++) begin
      send_pixel(4'd2, f[7:0], f[7:0], 1'b0, 1'b0);
      send_pixel(4'd2, f[7:0] + 8'd1, f[7:0], 1'b1, 1'b1);
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    int unsigned first_pixel;
    int unsigned first_report;
    int unsigned phase_start;
    int unsigned phase_len;
    phase = 0;
    first_pixel = pixels_sent;
    first_report = reports_predicted;
    while (pixels_sent - first_pixel < RANDOM_ITEMS ||
           reports_predicted - first_report < MIN_REPORTS) begin
      drain_results();
      case (phase)
        0: program_regs(4'd0, 4'd1, 9'd0);
        1: program_regs(4'd15, 4'd15, 9'd256);
        2: program_regs(4'd9, 4'd0, 9'd1);
        default: program_regs(ClassW'($urandom_range(0, 15)), GapW'($urandom_range(1, 15)),
                              WidthW'($urandom_range(0, 256)));
      endcase
      tx_idle_en = (phase % 3) != 1;
      rx_idle_en = (phase % 3) != 2;
      phase_start = pixels_sent;
      phase_len = $urandom_range(60, 140);
      while (pixels_sent - phase_start < phase_len) send_frame();
      phase++;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_no_run_frame();
    test_default_registers();
    test_run_edges();
    test_zero_gap();
    test_back_pressure();
    test_random_frames();
    drain_results();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
